/* rtl/core/keyed_lifo_stack_macros.svh */
// Assertion macros for the keyed LIFO stack.
// No dependencies; expects clk and rst_n in the including scope.
`ifndef KEYED_LIFO_STACK_MACROS_SVH
`define KEYED_LIFO_STACK_MACROS_SVH

`ifndef ASSERT_OFF

// Checked on every rising edge outside reset.
`define KLIFO_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define KLIFO_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define KLIFO_ASSERT(lbl, prop, msg)
`define KLIFO_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

/* rtl/core/klifo_pkg.sv */
// Shared codes and types for the keyed LIFO stack.
// No dependencies.
package klifo_pkg;

    localparam int KEY_W    = 32;
    localparam int ACTION_W = 3;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    localparam logic [ACTION_W-1:0] ACT_PUSH   = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_POP    = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_PEEK   = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_DELETE = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_SEARCH = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_COUNT  = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

    typedef logic [KEY_W-1:0] key_t;

    // Shift command broadcast to every cell; already qualified by accept.
    typedef struct packed {
        logic push;
        logic pop;
        logic del;
    } cell_ctrl_t;

endpackage

/* rtl/core/klifo_cell.sv */
// One storage cell of the keyed LIFO stack chain (index 0 is the top).
// Depends on klifo_pkg.
module klifo_cell (
    input  logic                  clk,
    input  klifo_pkg::cell_ctrl_t ctrl,
    input  klifo_pkg::key_t       key_in,
    input  klifo_pkg::key_t       above_key,
    input  klifo_pkg::key_t       below_key,
    input  logic                  valid,
    input  logic                  hit_in,
    output logic                  hit_out,
    output klifo_pkg::key_t       key
);
    import klifo_pkg::*;

    key_t key_reg;
    key_t key_next;

    // hit_out: a live match here or in any cell above
    assign hit_out = hit_in | (valid & (key_reg == key_in));
    assign key     = key_reg;

    always_comb
    begin
        key_next = key_reg;
        if (ctrl.push)
        begin
            key_next = above_key;
        end
        else if (ctrl.pop || (ctrl.del && hit_out))
        begin
            key_next = below_key;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

endmodule

/* rtl/core/keyed_lifo_stack.sv */
// Keyed LIFO stack top level: a chain of klifo_cell plus count and result register.
// Depends on klifo_pkg, klifo_cell and keyed_lifo_stack_macros.svh.
//
//  channel | signals                          | direction
//  --------+----------------------------------+----------
//  in      | in_valid in_ready action key_in  | request
//  out     | out_valid out_ready status       | result
//          | key_out entry_count              |
//
// One request per cycle while in_ready is high; its result lands in the output register in the next cycle.
// All cells compare against key_in at once; the hit prefix ripples down the chain.
// in_ready drops only while a finished result waits and out_ready is low.
// Reset clears the occupancy count (used_reg) and the output valid; cell contents and entry_count are not reset.
`include "keyed_lifo_stack_macros.svh"

module keyed_lifo_stack #(
    parameter int DEPTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [klifo_pkg::ACTION_W-1:0]      action,
    input  logic signed [klifo_pkg::KEY_W-1:0]  key_in,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [klifo_pkg::STATUS_W-1:0]      status,
    output logic signed [klifo_pkg::KEY_W-1:0]  key_out,
    output logic [klifo_pkg::COUNT_W-1:0]       entry_count
);
    import klifo_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0]    used_reg;
    logic [CNT_W-1:0]    used_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;
    key_t                key_out_reg;
    key_t                key_out_next;
    logic [COUNT_W-1:0]  count_reg;

    logic       in_fire;
    logic       empty;
    logic       full;
    logic       found;
    logic       push_ok;
    logic       empty_res;
    key_t       key_u;
    cell_ctrl_t ctrl;

    key_t             cell_key [DEPTH];
    logic [DEPTH:0]   hit;

    assign key_u    = key_t'(key_in);
    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;
    assign empty    = (used_reg == '0);
    assign full     = (used_reg == CNT_W'(DEPTH));
    assign hit[0]   = 1'b0;
    assign found    = hit[DEPTH];

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            key_t above;
            key_t below;
            if (gi == 0)
            begin : g_top
                assign above = key_u;
            end
            else
            begin : g_mid
                assign above = cell_key[gi-1];
            end
            if (gi == DEPTH - 1)
            begin : g_bot
                assign below = '0;
            end
            else
            begin : g_nbot
                assign below = cell_key[gi+1];
            end

            klifo_cell u_cell (
                .clk       (clk),
                .ctrl      (ctrl),
                .key_in    (key_u),
                .above_key (above),
                .below_key (below),
                .valid     (CNT_W'(gi) < used_reg),
                .hit_in    (hit[gi]),
                .hit_out   (hit[gi+1]),
                .key       (cell_key[gi])
            );
        end
    endgenerate

    always_comb
    begin
        ctrl         = '0;
        used_next    = used_reg;
        status_next  = ST_OK;
        key_out_next = '0;
        case (action)
            ACT_PUSH:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    ctrl.push = in_fire;
                    used_next = used_reg + 1'b1;
                end
            end
            ACT_POP, ACT_PEEK:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    key_out_next = cell_key[0];
                    if (action == ACT_POP)
                    begin
                        ctrl.pop  = in_fire;
                        used_next = used_reg - 1'b1;
                    end
                end
            end
            ACT_DELETE, ACT_SEARCH:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else if (!found)
                begin
                    status_next = ST_NOTFOUND;
                end
                else
                begin
                    // matched word equals the search key
                    key_out_next = key_u;
                    if (action == ACT_DELETE)
                    begin
                        ctrl.del  = in_fire;
                        used_next = used_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (in_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (in_fire)
            begin
                used_reg <= used_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            status_reg  <= status_next;
            key_out_reg <= key_out_next;
            count_reg   <= COUNT_W'(used_next);
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign key_out     = $signed(key_out_reg);
    assign entry_count = count_reg;

    assign push_ok   = in_fire && (action == ACT_PUSH) && !full;
    assign empty_res = out_valid_reg && (status_reg == ST_EMPTY);

    `KLIFO_ASSERT(a_used_bound, used_reg <= CNT_W'(DEPTH), "count above depth")
    `KLIFO_ASSERT(a_push_grows, push_ok |=> (used_reg == $past(used_reg) + 1'b1), "push lost")
    `KLIFO_ASSERT(a_empty_zero, empty_res |-> (count_reg == '0), "empty status, nonzero count")
    `KLIFO_ASSERT_ALWAYS(a_rst_idle, !rst_n |-> !out_valid_reg, "result valid during reset")

endmodule
